>>> src/madis_pkg.sv
// ----------------------------------------------------------------------------
// madis_pkg
// Shared types and constants for the mail address domain-insert scanner.
// ----------------------------------------------------------------------------
package madis_pkg;

    typedef logic [7:0] char_t;

    typedef enum logic [2:0] {
        ST_INSERT    = 3'd0,
        ST_PARSE_ERR = 3'd1,
        ST_DOMAIN    = 3'd2,
        ST_GROUP     = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_TOO_LONG  = 3'd5
    } status_t;

    localparam int          DOMAIN_W  = 12;
    localparam int          POS_OUT_W = 12;
    localparam int          DEPTH_W   = 13;
    localparam logic [12:0] DEPTH_MAX = 13'd8191;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_LT     = 8'h3C;
    localparam char_t CH_GT     = 8'h3E;
    localparam char_t CH_AT     = 8'h40;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_CR     = 8'h0D;

    // Space and the control bytes from tab through carriage return.
    function automatic logic is_ws(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

>>> src/mail_address_domain_insert_scan_top.sv
// ----------------------------------------------------------------------------
// mail_address_domain_insert_scan_top
// Scans one address header field a byte at a time and reports where the
// domain would be inserted, or why it cannot be.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: char_in with in_valid / in_stall. One header byte per item;
//   a zero byte ends the string and produces exactly one result item.
//   Output channel: status and insert_position with out_valid / out_stall.
//   Nonzero bytes produce no result item.
//   cfg_write / cfg_data load the domain length; write it only while idle.
// Timing:
//   A byte goes into the input register, the scan logic updates the state
//   from there, and the result register holds the answer for a zero byte.
//   One byte is taken every cycle as long as the result register is free or
//   being drained.
// Reset clears the scan state, the domain length and both valid flags.
// While the receiver stalls a waiting result, the pipeline holds; in_stall
// rises once the input register is also occupied.
// ----------------------------------------------------------------------------
module mail_address_domain_insert_scan_top
    import madis_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [DOMAIN_W-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           char_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [POS_OUT_W-1:0] insert_position
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = ((CW > DOMAIN_W) ? CW : DOMAIN_W) + 1;

    // Pipeline control and data registers.
    logic                in_valid_reg;
    char_t               char_reg;
    logic                out_valid_reg;
    status_t             status_reg,   status_next;
    logic [CW-1:0]       ins_reg,      ins_next;
    logic [DOMAIN_W-1:0] domain_length_reg;

    // Scan state.
    logic               escape_reg,       escape_next;
    logic               quote_reg,        quote_next;
    logic [DEPTH_W-1:0] depth_reg,        depth_next;
    logic               bracket_open_reg, bracket_open_next;
    logic               saw_domain_reg,   saw_domain_next;
    logic               saw_bracket_reg,  saw_bracket_next;
    logic               saw_group_reg,    saw_group_next;
    logic [CW-1:0]      lnp_reg,          lnp_next;
    logic               lnp_is_lt_reg,    lnp_is_lt_next;
    logic [CW-1:0]      bip_reg,          bip_next;
    logic               bempty_reg,       bempty_next;
    logic [CW-1:0]      comp_pos_reg,     comp_pos_next;
    logic               comp_seen_reg,    comp_seen_next;
    logic               first_sp_reg,     first_sp_next;
    logic [CW-1:0]      count_reg,        count_next;

    logic advance;
    logic scan_en;
    logic ws;
    logic [DEPTH_W-1:0] depth_a;
    logic [DEPTH_W-1:0] depth_b;
    logic quote_a;
    logic esc_a;
    logic plain;
    logic empty;
    logic [CW-1:0] ins_cand;
    logic [SW-1:0] need;
    logic [31:0]   ins_wide;

    assign advance  = !out_valid_reg || !out_stall;
    assign scan_en  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            domain_length_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_in;
        end
    end

    // Per-byte scan update and end-of-string evaluation.
    always_comb
    begin
        ws = is_ws(char_reg);

        escape_next       = escape_reg;
        quote_next        = quote_reg;
        depth_next        = depth_reg;
        bracket_open_next = bracket_open_reg;
        saw_domain_next   = saw_domain_reg;
        saw_bracket_next  = saw_bracket_reg;
        saw_group_next    = saw_group_reg;
        lnp_next          = lnp_reg;
        lnp_is_lt_next    = lnp_is_lt_reg;
        bip_next          = bip_reg;
        bempty_next       = bempty_reg;
        comp_pos_next     = comp_pos_reg;
        comp_seen_next    = comp_seen_reg;
        first_sp_next     = first_sp_reg;
        count_next        = count_reg;

        // Depth and quote updates chain in the same order as the byte rules.
        depth_a = depth_reg;
        if (char_reg == CH_LPAREN && !escape_reg && !quote_reg && depth_reg < DEPTH_MAX)
        begin
            depth_a = depth_reg + 1'b1;
        end
        quote_a = quote_reg;
        if (char_reg == CH_DQUOTE && !escape_reg && depth_a == '0)
        begin
            quote_a = !quote_reg;
        end
        depth_b = depth_a;
        if (char_reg == CH_RPAREN && !escape_reg && !quote_a && depth_a != '0)
        begin
            depth_b = depth_a - 1'b1;
        end
        esc_a = (char_reg == CH_BSLASH) && !escape_reg && depth_b == '0 && !quote_a;
        plain = !esc_a && depth_b == '0 && !quote_a;

        // End-of-string result.
        if (bracket_open_reg || saw_bracket_reg)
        begin
            empty    = bempty_reg;
            ins_cand = bip_reg;
        end
        else if (comp_seen_reg)
        begin
            empty    = 1'b0;
            ins_cand = comp_pos_reg + 1'b1;
        end
        else
        begin
            empty    = (count_reg == '0) || first_sp_reg;
            ins_cand = CW'(1);
        end
        need = SW'(count_reg) + SW'(1) + SW'(domain_length_reg);

        if (escape_reg || quote_reg || depth_reg != '0 || bracket_open_reg)
        begin
            status_next = ST_PARSE_ERR;
        end
        else if (saw_domain_reg)
        begin
            status_next = ST_DOMAIN;
        end
        else if (saw_group_reg)
        begin
            status_next = ST_GROUP;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (need >= SW'(BUFFER_BYTES))
        begin
            status_next = ST_TOO_LONG;
        end
        else
        begin
            status_next = ST_INSERT;
        end
        ins_next = (status_next == ST_INSERT) ? ins_cand : '0;

        if (char_reg == CH_NUL)
        begin
            // The string is done: return to the start-of-string state.
            escape_next       = 1'b0;
            quote_next        = 1'b0;
            depth_next        = '0;
            bracket_open_next = 1'b0;
            saw_domain_next   = 1'b0;
            saw_bracket_next  = 1'b0;
            saw_group_next    = 1'b0;
            lnp_next          = '0;
            lnp_is_lt_next    = 1'b0;
            bip_next          = '0;
            bempty_next       = 1'b0;
            comp_pos_next     = '0;
            comp_seen_next    = 1'b0;
            first_sp_next     = 1'b0;
            count_next        = '0;
        end
        else
        begin
            if (count_reg == '0)
            begin
                first_sp_next = ws;
            end
            depth_next  = depth_b;
            quote_next  = quote_a;
            escape_next = esc_a;
            if (plain)
            begin
                if (char_reg == CH_LT && !bracket_open_reg)
                begin
                    bracket_open_next = 1'b1;
                    saw_bracket_next  = 1'b1;
                end
                if (char_reg == CH_GT && bracket_open_reg)
                begin
                    bracket_open_next = 1'b0;
                    bip_next          = lnp_reg + 1'b1;
                    bempty_next       = lnp_is_lt_reg;
                end
                if (char_reg == CH_AT)
                begin
                    saw_domain_next = 1'b1;
                end
                if (char_reg == CH_COLON)
                begin
                    saw_group_next = 1'b1;
                end
            end
            if (depth_b == '0 && char_reg != CH_RPAREN && !ws)
            begin
                comp_pos_next  = count_reg;
                comp_seen_next = 1'b1;
            end
            if (!ws)
            begin
                lnp_next       = count_reg;
                lnp_is_lt_next = (char_reg == CH_LT);
            end
            if (count_reg < CW'(BUFFER_BYTES))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg       <= 1'b0;
            quote_reg        <= 1'b0;
            depth_reg        <= '0;
            bracket_open_reg <= 1'b0;
            saw_domain_reg   <= 1'b0;
            saw_bracket_reg  <= 1'b0;
            saw_group_reg    <= 1'b0;
            lnp_reg          <= '0;
            lnp_is_lt_reg    <= 1'b0;
            bip_reg          <= '0;
            bempty_reg       <= 1'b0;
            comp_pos_reg     <= '0;
            comp_seen_reg    <= 1'b0;
            first_sp_reg     <= 1'b0;
            count_reg        <= '0;
        end
        else if (scan_en)
        begin
            escape_reg       <= escape_next;
            quote_reg        <= quote_next;
            depth_reg        <= depth_next;
            bracket_open_reg <= bracket_open_next;
            saw_domain_reg   <= saw_domain_next;
            saw_bracket_reg  <= saw_bracket_next;
            saw_group_reg    <= saw_group_next;
            lnp_reg          <= lnp_next;
            lnp_is_lt_reg    <= lnp_is_lt_next;
            bip_reg          <= bip_next;
            bempty_reg       <= bempty_next;
            comp_pos_reg     <= comp_pos_next;
            comp_seen_reg    <= comp_seen_next;
            first_sp_reg     <= first_sp_next;
            count_reg        <= count_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && (char_reg == CH_NUL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_en && char_reg == CH_NUL)
        begin
            status_reg <= status_next;
            ins_reg    <= ins_next;
        end
    end

    assign ins_wide        = 32'(ins_reg);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign insert_position = ins_wide[POS_OUT_W-1:0];

    // The input side only stalls while a result is waiting on the receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_INSERT) |-> (ins_reg == '0))
        else $error("nonzero insert position on a non-insert status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_INSERT) |-> (ins_reg != '0))
        else $error("insert status with a zero position");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_BYTES))
        else $error("byte count beyond its saturation value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_en && char_reg == CH_NUL) |=>
            (count_reg == '0 && depth_reg == '0 && !quote_reg && !escape_reg))
        else $error("scan state not cleared after end of string");

endmodule
